// File: rtl/core/bmd_pkg.sv
`timescale 1ns / 1ps

package bmd_pkg;

  localparam int unsigned SIG_LEN = 4;
  localparam logic [23:0] MIN_LENGTH = 24'd12;
  localparam logic [23:0] SECTION0_LEN = 24'd8;

  // signature letters, first letter in the lowest byte
  localparam logic [SIG_LEN-1:0][7:0] SIG_BYTES = {8'h52, 8'h46, 8'h55, 8'h42};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_TRUNC = 2'd2,
    ST_NONE  = 2'd3
  } status_t;

  // shape of the burst that one input transfer produces
  typedef enum logic [1:0] {
    KIND_ONE   = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_SIG   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    status_t     status;
    logic [31:0] offset;
  } burst_t;

endpackage

// File: rtl/core/bufr_message_deframer_unit.sv
`timescale 1ns / 1ps

// latency: a result is offered on the master side the cycle after its input transfer
// throughput: while m_tready is high, one input byte per cycle; a found signature gives
// a burst of four results, one per cycle, and a header byte with a short length gives
// two results; the slave side stalls until the last result of a burst is taken
// reset (rst, synchronous): back to hunting, stream offset zero, output empty
module bufr_message_deframer_unit
  import bmd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // data_byte
  input  logic        s_tlast,  // stream_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // out_byte, start_offset
  output logic [2:0]  m_tuser,  // message_start, status
  output logic        m_tlast   // last
);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  match_count, match_count_next;
  logic [1:0]  header_index, header_index_next;
  logic [23:0] declared_length, declared_length_next;
  logic [23:0] bytes_left, bytes_left_next;
  logic [31:0] stream_position, stream_position_next;

  burst_t      burst, burst_next;
  logic        burst_fire;
  logic        busy;
  logic [1:0]  idx;
  logic [1:0]  last_idx;
  logic        s_xfer, m_xfer, burst_done;
  logic [23:0] bytes_dec;

  // out byte fields for the current burst entry
  logic [7:0]  o_byte;
  logic        o_start;
  logic [31:0] o_offset;
  logic        o_last;
  status_t     o_status;

  always_comb begin
    unique case (burst.kind)
      KIND_SHORT: last_idx = 2'd1;
      KIND_SIG:   last_idx = 2'd3;
      default:    last_idx = 2'd0;
    endcase
  end

  assign m_xfer     = m_tvalid && m_tready;
  assign burst_done = m_xfer && (idx == last_idx);
  assign s_tready   = !busy || burst_done;
  assign s_xfer     = s_tvalid && s_tready;
  assign bytes_dec  = bytes_left - 24'd1;

  always_comb begin
    phase_next           = phase;
    match_count_next     = match_count;
    header_index_next    = header_index;
    declared_length_next = declared_length;
    bytes_left_next      = bytes_left;
    stream_position_next = stream_position + 32'd1;
    burst_fire           = 1'b0;
    burst_next.kind      = KIND_ONE;
    burst_next.data      = s_tdata;
    burst_next.last      = 1'b0;
    burst_next.status    = ST_OK;
    burst_next.offset    = stream_position - 32'(SIG_LEN - 1);
    if (s_tlast) begin
      burst_fire           = 1'b1;
      burst_next.data      = 8'h00;
      burst_next.last      = 1'b1;
      burst_next.status    = (phase == PH_HEADER || phase == PH_BODY) ? ST_TRUNC : ST_NONE;
      phase_next           = PH_HUNT;
      match_count_next     = 2'd0;
      header_index_next    = 2'd0;
      declared_length_next = 24'd0;
      bytes_left_next      = 24'd0;
      stream_position_next = 32'd0;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          burst_fire = 1'b1;
          if (header_index != 2'd3) begin
            declared_length_next = {declared_length[15:0], s_tdata};
            header_index_next    = header_index + 2'd1;
          end else if (declared_length < MIN_LENGTH) begin
            burst_next.kind   = KIND_SHORT;
            phase_next        = PH_HUNT;
            match_count_next  = 2'd0;
            header_index_next = 2'd0;
          end else begin
            bytes_left_next   = declared_length - SECTION0_LEN;
            phase_next        = PH_BODY;
            header_index_next = 2'd0;
          end
        end
        PH_BODY: begin
          burst_fire      = 1'b1;
          bytes_left_next = bytes_dec;
          if (bytes_dec == 24'd0) begin
            burst_next.last  = 1'b1;
            phase_next       = PH_HUNT;
            match_count_next = 2'd0;
          end
        end
        default: begin
          if (s_tdata == SIG_BYTES[match_count]) begin
            if (match_count == 2'(SIG_LEN - 1)) begin
              burst_fire           = 1'b1;
              burst_next.kind      = KIND_SIG;
              phase_next           = PH_HEADER;
              header_index_next    = 2'd0;
              declared_length_next = 24'd0;
              match_count_next     = 2'd0;
            end else begin
              match_count_next = match_count + 2'd1;
            end
          end else begin
            match_count_next = (s_tdata == SIG_BYTES[0]) ? 2'd1 : 2'd0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      match_count     <= 2'd0;
      header_index    <= 2'd0;
      declared_length <= 24'd0;
      bytes_left      <= 24'd0;
      stream_position <= 32'd0;
      busy            <= 1'b0;
      idx             <= 2'd0;
    end else begin
      if (s_xfer) begin
        phase           <= phase_next;
        match_count     <= match_count_next;
        header_index    <= header_index_next;
        declared_length <= declared_length_next;
        bytes_left      <= bytes_left_next;
        stream_position <= stream_position_next;
      end
      if (s_xfer && burst_fire) begin
        busy <= 1'b1;
        idx  <= 2'd0;
      end else if (burst_done) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else if (m_xfer) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer && burst_fire) begin
      burst <= burst_next;
    end
  end

  always_comb begin
    o_byte   = burst.data;
    o_start  = 1'b0;
    o_offset = 32'd0;
    o_last   = burst.last;
    o_status = burst.status;
    unique case (burst.kind)
      KIND_SIG: begin
        o_byte   = SIG_BYTES[idx];
        o_start  = (idx == 2'd0);
        o_offset = (idx == 2'd0) ? burst.offset : 32'd0;
        o_last   = 1'b0;
        o_status = ST_OK;
      end
      KIND_SHORT: begin
        // header byte first, then the short length status
        if (idx == 2'd0) begin
          o_last   = 1'b0;
          o_status = ST_OK;
        end else begin
          o_byte   = 8'h00;
          o_last   = 1'b1;
          o_status = ST_SHORT;
        end
      end
      default: begin
        o_byte = burst.data;
      end
    endcase
  end

  assign m_tvalid = busy;
  assign m_tdata  = {o_offset, o_byte};
  assign m_tuser  = {o_status, o_start};
  assign m_tlast  = o_last;

endmodule

// File: rtl/core/bmd_checker.sv
`timescale 1ns / 1ps

module bmd_checker
  import bmd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // output empty straight after reset
  a_reset_empty: assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_tvalid)
    else $error("result offered right after reset");

  // a message start is a plain signature letter, never last
  a_start_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |->
      (!m_tlast && m_tuser[2:1] == ST_OK && m_tdata[7:0] == SIG_BYTES[0]))
    else $error("malformed message start");

  // status results carry no byte and close the run
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] != ST_OK) |-> (m_tlast && m_tdata[7:0] == 8'h00))
    else $error("status result not last or carries data");

  // the second signature letter follows a start transfer at once
  a_sig_burst: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tuser[0]) |=>
      (m_tvalid && !m_tuser[0] && m_tdata[7:0] == SIG_BYTES[1]))
    else $error("signature burst broken");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind bufr_message_deframer_unit bmd_checker u_bmd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
